[rtl/integral_image_with_squares_defines.svh]
// Assertion macros for the integral image block.
// Used by integral_image_with_squares.sv; no other dependencies.
`ifndef INTEGRAL_IMAGE_WITH_SQUARES_DEFINES_SVH
`define INTEGRAL_IMAGE_WITH_SQUARES_DEFINES_SVH

`ifndef SYNTHESIS
`define IIS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IIS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define IIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/iis_pkg.sv]
// Shared types and constants for the integral image block.
// No dependencies.
`timescale 1ns / 1ps

package iis_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int TOTAL_W    = 30;
    localparam int SQ_TOTAL_W = 38;
    localparam int LANES      = 4;

    localparam int IN_DATA_W  = LANES * SAMPLE_W;
    localparam int OUT_DATA_W = LANES * (TOTAL_W + SQ_TOTAL_W);

    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;

    localparam int CHANNELS_W = 3;
    localparam int GEOM_W     = 12;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_HEIGHT   = 2048;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam logic [CHANNELS_W-1:0] RST_CHANNELS     = 3'd1;
    localparam logic [GEOM_W-1:0]     RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [GEOM_W-1:0]     RST_IMAGE_HEIGHT = 12'd480;
    localparam logic                  RST_WITH_SQUARES = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHANNELS     = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_WITH_SQUARES = 2'd3
    } t_cfg_index;

endpackage

[rtl/integral_image_with_squares.sv]
// An accepted request goes through the stage 1 register, then the output register.
// Throughput: one pixel per cycle unless the output stalls; the line store is read at
// accept and written as stage 1 advances, with a one-entry bypass for a column revisited at once.
// Reset (i_rst_n low, synchronous): position, row sums and handshake cleared; config set to defaults.
// The line store is not cleared; it is written during the first row of each frame.
// Integral image block top level; depends on iis_pkg and the defines header.
`timescale 1ns / 1ps
`include "integral_image_with_squares_defines.svh"

module integral_image_with_squares #(
    parameter int MAX_WIDTH    = iis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = iis_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = iis_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [iis_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [iis_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // sample_0, sample_1, sample_2, sample_3
    input  logic [iis_pkg::IN_DATA_W-1:0]        i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // total_0..total_3, square_total_0..square_total_3
    output logic [iis_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    // row_end
    output logic                                 o_m_tlast,
    // frame_end
    output logic                                 o_m_tuser
);

    localparam int LANES = iis_pkg::LANES;
    localparam int SW    = iis_pkg::SAMPLE_W;
    localparam int TW    = iis_pkg::TOTAL_W;
    localparam int QW    = iis_pkg::SQ_TOTAL_W;
    localparam int LW    = TW + QW;
    localparam int STW   = MAX_CHANNELS * LW;
    localparam int LOG_W = $clog2(MAX_WIDTH);
    localparam int CW    = (MAX_WIDTH > 1) ? LOG_W : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RSW   = SW + LOG_W;
    localparam int RQW   = 2 * SW + LOG_W;
    localparam int GW    = iis_pkg::GEOM_W;
    localparam int CHW   = iis_pkg::CHANNELS_W;

    // configuration
    logic [CHW-1:0] r_channels;
    logic [GW-1:0]  r_image_width;
    logic [GW-1:0]  r_image_height;
    logic           r_with_squares;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels     <= iis_pkg::RST_CHANNELS;
            r_image_width  <= iis_pkg::RST_IMAGE_WIDTH;
            r_image_height <= iis_pkg::RST_IMAGE_HEIGHT;
            r_with_squares <= iis_pkg::RST_WITH_SQUARES;
        end else if (i_cfg_wr_en) begin
            case (iis_pkg::t_cfg_index'(i_cfg_index))
                iis_pkg::CFG_CHANNELS:     r_channels     <= i_cfg_data[CHW-1:0];
                iis_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[GW-1:0];
                iis_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[GW-1:0];
                iis_pkg::CFG_WITH_SQUARES: r_with_squares <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_advance;
    logic in_acc;

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_advance = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || s1_advance;
    assign in_acc     = i_s_tvalid && o_s_tready;

    // position and geometry at accept
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [CW:0]    w_eff;
    logic [RW:0]    h_eff;
    logic [CHW-1:0] cn_eff;
    logic [CW-1:0]  col_c;
    logic           last_col;
    logic           last_row;
    logic [CW-1:0]  n_col;
    logic [RW-1:0]  n_row;
    logic [LANES-1:0] used;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = (CW+1)'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = (RW+1)'(1);
        end else if (int'(r_image_height) > MAX_HEIGHT) begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (RW+1)'(r_image_height);
        end
        if (r_channels == '0) begin
            cn_eff = CHW'(1);
        end else if (int'(r_channels) > MAX_CHANNELS) begin
            cn_eff = CHW'(MAX_CHANNELS);
        end else begin
            cn_eff = r_channels;
        end
        for (int k = 0; k < LANES; k++) begin
            used[k] = CHW'(k) < cn_eff;
        end
        if ({1'b0, r_col} >= w_eff) begin
            col_c = CW'(w_eff - (CW+1)'(1));
        end else begin
            col_c = r_col;
        end
        last_col = ({1'b0, col_c} + (CW+1)'(1)) >= w_eff;
        last_row = ({1'b0, r_row} + (RW+1)'(1)) >= h_eff;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = col_c + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1 register
    logic [SW-1:0]    r_s1_sample [LANES];
    logic [LANES-1:0] r_s1_used;
    logic [CW-1:0]    r_s1_addr;
    logic             r_s1_first_col;
    logic             r_s1_top_row;
    logic             r_s1_last_col;
    logic             r_s1_last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < LANES; k++) begin
                r_s1_sample[k] <= i_s_tdata[k*SW +: SW];
            end
            r_s1_used      <= used;
            r_s1_addr      <= col_c;
            r_s1_first_col <= (col_c == '0);
            r_s1_top_row   <= (r_row == '0);
            r_s1_last_col  <= last_col;
            r_s1_last_row  <= last_row;
        end
    end

    // line store of the previous row's totals
    logic [STW-1:0] r_store [MAX_WIDTH];
    logic [STW-1:0] r_rd_data;
    logic [STW-1:0] r_fwd_data;
    logic           r_fwd_sel;
    logic [STW-1:0] wr_word;
    logic [STW-1:0] above_word;

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_store[r_s1_addr] <= wr_word;
        end
        if (in_acc) begin
            r_rd_data <= r_store[col_c];
        end
    end

    // read and write on one column at the same edge: take the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_sel <= 1'b0;
        end else if (in_acc) begin
            r_fwd_sel <= s1_advance && (r_s1_addr == col_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_data <= wr_word;
        end
    end

    assign above_word = r_fwd_sel ? r_fwd_data : r_rd_data;

    // per-lane sums
    logic [RSW-1:0] r_row_sum [LANES];
    logic [RQW-1:0] r_row_sq  [LANES];
    logic [RSW-1:0] n_row_sum [LANES];
    logic [RQW-1:0] n_row_sq  [LANES];
    logic [TW-1:0]  lane_tot  [LANES];
    logic [QW-1:0]  lane_sqt  [LANES];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [SW-1:0]   s;
        logic [2*SW-1:0] sq;
        logic [LW-1:0]   above_raw;
        logic [TW-1:0]   above_tot;
        logic [QW-1:0]   above_sq;
        logic [TW-1:0]   tot;
        logic [QW-1:0]   sqt;

        assign s  = r_s1_used[k] ? r_s1_sample[k] : '0;
        assign sq = s * s;

        assign n_row_sum[k] = !r_s1_used[k] ? '0 :
                              r_s1_first_col ? RSW'(s) : r_row_sum[k] + RSW'(s);
        assign n_row_sq[k]  = !r_s1_used[k] ? '0 :
                              r_s1_first_col ? RQW'(sq) : r_row_sq[k] + RQW'(sq);

        if (k < MAX_CHANNELS) begin : g_store
            assign above_raw = above_word[k*LW +: LW];
            assign wr_word[k*LW +: LW] = r_s1_used[k] ? {sqt, tot} : above_raw;
        end else begin : g_none
            assign above_raw = '0;
        end

        assign above_tot = r_s1_top_row ? '0 : above_raw[TW-1:0];
        assign above_sq  = r_s1_top_row ? '0 : above_raw[LW-1:TW];
        assign tot = TW'(n_row_sum[k]) + above_tot;
        assign sqt = QW'(n_row_sq[k]) + above_sq;

        assign lane_tot[k] = r_s1_used[k] ? tot : '0;
        assign lane_sqt[k] = (r_s1_used[k] && r_with_squares) ? sqt : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                r_row_sum[k] <= '0;
                r_row_sq[k]  <= '0;
            end
        end else if (s1_advance) begin
            for (int k = 0; k < LANES; k++) begin
                r_row_sum[k] <= n_row_sum[k];
                r_row_sq[k]  <= n_row_sq[k];
            end
        end
    end

    // output register
    logic [TW-1:0] r_out_tot [LANES];
    logic [QW-1:0] r_out_sq  [LANES];
    logic          r_out_row_end;
    logic          r_out_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            for (int k = 0; k < LANES; k++) begin
                r_out_tot[k] <= lane_tot[k];
                r_out_sq[k]  <= lane_sqt[k];
            end
            r_out_row_end   <= r_s1_last_col;
            r_out_frame_end <= r_s1_last_col && r_s1_last_row;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_sq[3], r_out_sq[2], r_out_sq[1], r_out_sq[0],
                         r_out_tot[3], r_out_tot[2], r_out_tot[1], r_out_tot[0]};
    assign o_m_tlast  = r_out_row_end;
    assign o_m_tuser  = r_out_frame_end;

    // checks
    `IIS_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, s1_advance, r_out_valid)
    `IIS_ASSERT_NEXT(a_bypass_taken, i_clk, i_rst_n, in_acc && s1_advance && (r_s1_addr == col_c), r_fwd_sel)
    `IIS_ASSERT_SAME(a_frame_in_row, i_clk, i_rst_n, r_out_valid && r_out_frame_end, r_out_row_end)
    `IIS_ASSERT_SAME(a_unused_zero, i_clk, i_rst_n, r_s1_valid && !r_s1_used[0], 1'b0)

endmodule

[dv/tb_integral_image_with_squares.sv]
// Self-checking testbench for integral_image_with_squares: directed rows, then random frames.
// Results are predicted per pixel and compared field by field. Depends on iis_pkg and the RTL.
`timescale 1ns / 1ps

module tb_integral_image_with_squares;

    localparam int LANES            = iis_pkg::LANES;
    localparam int SAMPLE_W         = iis_pkg::SAMPLE_W;
    localparam int TOTAL_W          = iis_pkg::TOTAL_W;
    localparam int SQ_TOTAL_W       = iis_pkg::SQ_TOTAL_W;
    localparam int IN_DATA_W        = iis_pkg::IN_DATA_W;
    localparam int OUT_DATA_W       = iis_pkg::OUT_DATA_W;
    localparam int CFG_DATA_W       = iis_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W      = iis_pkg::CFG_INDEX_W;
    localparam int CHANNELS_W       = iis_pkg::CHANNELS_W;
    localparam int GEOM_W           = iis_pkg::GEOM_W;
    localparam int DEF_MAX_WIDTH    = iis_pkg::DEF_MAX_WIDTH;
    localparam int DEF_MAX_HEIGHT   = iis_pkg::DEF_MAX_HEIGHT;
    localparam int DEF_MAX_CHANNELS = iis_pkg::DEF_MAX_CHANNELS;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;

    typedef logic [LANES-1:0][SAMPLE_W-1:0] t_pixel;

    typedef struct packed {
        logic                                  frame_end;
        logic                                  row_end;
        logic [LANES-1:0][SQ_TOTAL_W-1:0]      sq_total;
        logic [LANES-1:0][TOTAL_W-1:0]         total;
    } t_sums;

    typedef enum logic {STEP_WRITE, STEP_PIXEL} t_step_kind;

    typedef struct packed {
        t_step_kind             kind;
        iis_pkg::t_cfg_index    reg_idx;
        logic [CFG_DATA_W-1:0]  reg_value;
        t_pixel                 px;
        logic                   known;
        t_sums                  want;
    } t_plan_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   o_m_tlast;
    logic                   o_m_tuser;

    integral_image_with_squares dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the block: registers, line store, row sums, raster position
    logic [CHANNELS_W-1:0] reg_channels;
    logic [GEOM_W-1:0]     reg_width;
    logic [GEOM_W-1:0]     reg_height;
    logic                  reg_squares;
    bit [TOTAL_W-1:0]      line_total [0:STORE_DEPTH-1];
    bit [SQ_TOTAL_W-1:0]   line_sq_total [0:STORE_DEPTH-1];
    bit [63:0]             row_sum [LANES];
    bit [63:0]             row_sq_sum [LANES];
    int unsigned           col_pos;
    int unsigned           row_pos;

    t_sums       expected_sums[$];
    t_plan_row   directed_plan[$];
    int          mismatches;
    int          results_seen;
    int          pixels_sent;
    int          frames_run;
    int          cycles;
    int          idle_odds;
    bit          calm;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_sums integrate_pixel(t_pixel px);
        t_sums       r;
        int unsigned cn, w, h, col, row, idx;
        bit          last_col, last_row;
        bit [63:0]   s, sq, tot, sq_tot;
        cn = clamp_to(reg_channels, DEF_MAX_CHANNELS);
        w = clamp_to(reg_width, DEF_MAX_WIDTH);
        h = clamp_to(reg_height, DEF_MAX_HEIGHT);
        col = (col_pos >= w) ? w - 1 : col_pos;
        row = row_pos;
        last_col = (col + 1 >= w);
        last_row = (row + 1 >= h);
        r = '0;
        for (int k = 0; k < LANES; k++) begin
            if (k < cn) begin
                idx = (col * DEF_MAX_CHANNELS + k) % STORE_DEPTH;
                s = px[k];
                sq = s * s;
                if (col == 0) begin
                    row_sum[k] = s;
                    row_sq_sum[k] = sq;
                end else begin
                    row_sum[k] += s;
                    row_sq_sum[k] += sq;
                end
                tot = row_sum[k];
                sq_tot = row_sq_sum[k];
                if (row != 0) begin
                    tot += line_total[idx];
                    sq_tot += line_sq_total[idx];
                end
                line_total[idx] = tot[TOTAL_W-1:0];
                line_sq_total[idx] = sq_tot[SQ_TOTAL_W-1:0];
                r.total[k] = tot[TOTAL_W-1:0];
                r.sq_total[k] = reg_squares ? sq_tot[SQ_TOTAL_W-1:0] : '0;
            end else begin
                row_sum[k] = 0;
                row_sq_sum[k] = 0;
            end
        end
        r.row_end = last_col;
        r.frame_end = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end
        return r;
    endfunction

    function automatic t_plan_row reg_row(iis_pkg::t_cfg_index idx,
                                          logic [CFG_DATA_W-1:0] value);
        t_plan_row r;
        r = '0;
        r.kind = STEP_WRITE;
        r.reg_idx = idx;
        r.reg_value = value;
        return r;
    endfunction

    function automatic t_plan_row pix_row(logic [IN_DATA_W-1:0] px);
        t_plan_row r;
        r = '0;
        r.kind = STEP_PIXEL;
        r.px = px;
        return r;
    endfunction

    // only lane 0 carries a sum in the rows typed in by hand
    function automatic t_plan_row known_row(logic [IN_DATA_W-1:0] px, longint unsigned tot0,
                                            longint unsigned sq0, bit row_end, bit frame_end);
        t_plan_row r;
        r = pix_row(px);
        r.known = 1'b1;
        r.want.total[0] = tot0[TOTAL_W-1:0];
        r.want.sq_total[0] = sq0[SQ_TOTAL_W-1:0];
        r.want.row_end = row_end;
        r.want.frame_end = frame_end;
        return r;
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        px = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < LANES; k++) begin
                px[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < 40) begin
            $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        end
        mismatches++;
    endtask

    // called and left at a falling edge
    task automatic push_pixel(input t_pixel px, input bit known, input t_sums want);
        t_sums predicted;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = px;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = integrate_pixel(px);
        expected_sums.push_back(known ? want : predicted);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // block must be drained before any register write
    task automatic write_reg(input iis_pkg::t_cfg_index idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_s_tvalid = 1'b0;
        while (expected_sums.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        case (idx)
            iis_pkg::CFG_CHANNELS:     reg_channels = value[CHANNELS_W-1:0];
            iis_pkg::CFG_IMAGE_WIDTH:  reg_width = value[GEOM_W-1:0];
            iis_pkg::CFG_IMAGE_HEIGHT: reg_height = value[GEOM_W-1:0];
            iis_pkg::CFG_WITH_SQUARES: reg_squares = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // one frame from the top-left pixel; geometry is only ever shrunk mid-frame so that
    // every line store entry read has been written on the row above; an oversized fixed
    // geometry is cut down after a short stretch
    task automatic run_frame(input bit fixed_geom, input logic [GEOM_W-1:0] w_raw,
                             input logic [GEOM_W-1:0] h_raw, inout int counted);
        int v, shrink_at, n;
        v = $urandom_range(0, 3);
        idle_odds = (calm || v == 0) ? 0 : (1 << v);
        if (fixed_geom) begin
            write_reg(iis_pkg::CFG_IMAGE_WIDTH, w_raw);
            write_reg(iis_pkg::CFG_IMAGE_HEIGHT, h_raw);
        end else begin
            if (reg_width > 40 || reg_width == 0 || $urandom_range(0, 3) != 0) begin
                v = $urandom_range(0, 9);
                write_reg(iis_pkg::CFG_IMAGE_WIDTH, (v == 0) ? 0 :
                          (v == 9) ? $urandom_range(13, 40) : $urandom_range(1, 12));
            end
            if (reg_height > 6 || $urandom_range(0, 3) != 0) begin
                write_reg(iis_pkg::CFG_IMAGE_HEIGHT, $urandom_range(0, 6));
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            write_reg(iis_pkg::CFG_CHANNELS, $urandom_range(0, 7));
        end
        if ($urandom_range(0, 3) != 0) begin
            write_reg(iis_pkg::CFG_WITH_SQUARES, $urandom_range(0, 1));
        end
        shrink_at = fixed_geom ? 24 :
                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : -1;
        n = 0;
        do begin
            push_pixel(random_pixel(), 1'b0, '0);
            n++;
            counted++;
            if (n == shrink_at && (col_pos != 0 || row_pos != 0)) begin
                if (fixed_geom) begin
                    if (w_raw > 24) begin
                        write_reg(iis_pkg::CFG_IMAGE_WIDTH, $urandom_range(0, 24));
                    end
                    if (h_raw > 24) begin
                        write_reg(iis_pkg::CFG_IMAGE_HEIGHT, $urandom_range(0, 24));
                    end
                end else begin
                    case ($urandom_range(0, 2))
                        0: write_reg(iis_pkg::CFG_IMAGE_WIDTH,
                                     $urandom_range(0, clamp_to(reg_width, DEF_MAX_WIDTH)));
                        1: write_reg(iis_pkg::CFG_IMAGE_HEIGHT,
                                     $urandom_range(0, clamp_to(reg_height, DEF_MAX_HEIGHT)));
                        default: write_reg(iis_pkg::CFG_CHANNELS,
                                     $urandom_range(0, clamp_to(reg_channels,
                                                                DEF_MAX_CHANNELS)));
                    endcase
                end
            end
        end while (col_pos != 0 || row_pos != 0);
        frames_run++;
    endtask

    initial begin : sink_pacing
        forever begin
            @(negedge i_clk);
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_sums got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.total = o_m_tdata[LANES*TOTAL_W-1:0];
            got.sq_total = o_m_tdata[OUT_DATA_W-1:LANES*TOTAL_W];
            if (expected_sums.size() == 0) begin
                report_mismatch("result with no request outstanding", 0, 0);
            end else begin
                want = expected_sums.pop_front();
                for (int k = 0; k < LANES; k++) begin
                    if (got.total[k] !== want.total[k]) begin
                        report_mismatch($sformatf("total_%0d", k), got.total[k], want.total[k]);
                    end
                    if (got.sq_total[k] !== want.sq_total[k]) begin
                        report_mismatch($sformatf("square_total_%0d", k),
                                        got.sq_total[k], want.sq_total[k]);
                    end
                end
                if (o_m_tlast !== want.row_end) begin
                    report_mismatch("row_end", o_m_tlast, want.row_end);
                end
                if (o_m_tuser !== want.frame_end) begin
                    report_mismatch("frame_end", o_m_tuser, want.frame_end);
                end
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_sums.size());
            $display("tb_integral_image_with_squares NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int random_pixels;
        reg_channels = iis_pkg::RST_CHANNELS;
        reg_width = iis_pkg::RST_IMAGE_WIDTH;
        reg_height = iis_pkg::RST_IMAGE_HEIGHT;
        reg_squares = iis_pkg::RST_WITH_SQUARES;
        col_pos = 0;
        row_pos = 0;
        idle_odds = 3;
        calm = 1'b0;
        random_pixels = 0;

        // reset values first, then shrinking geometry mid-frame, out-of-range registers,
        // squares off, small frames with all lanes and with fewer, a one-column frame cut short
        directed_plan.push_back(known_row(32'hFFFFFFFF, 255, 65025, 0, 0));
        directed_plan.push_back(known_row(32'h00000000, 255, 65025, 0, 0));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_WIDTH, 1));
        directed_plan.push_back(known_row(32'h7F7F7F7F, 127, 16129, 1, 0));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_HEIGHT, 1));
        directed_plan.push_back(known_row(32'h01010101, 128, 16130, 1, 1));
        directed_plan.push_back(reg_row(iis_pkg::CFG_CHANNELS, 0));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_WIDTH, 0));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_HEIGHT, 0));
        directed_plan.push_back(known_row(32'hFFFFFFFF, 255, 65025, 1, 1));
        directed_plan.push_back(reg_row(iis_pkg::CFG_WITH_SQUARES, 0));
        directed_plan.push_back(known_row(32'hFFFFFFFF, 255, 0, 1, 1));
        directed_plan.push_back(reg_row(iis_pkg::CFG_CHANNELS, 7));
        directed_plan.push_back(reg_row(iis_pkg::CFG_WITH_SQUARES, 1));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_WIDTH, 3));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_HEIGHT, 2));
        directed_plan.push_back(pix_row(32'hFFFFFFFF));
        directed_plan.push_back(pix_row(32'h00000000));
        directed_plan.push_back(pix_row(32'hFFFFFFFF));
        directed_plan.push_back(pix_row(32'hFE017F80));
        directed_plan.push_back(pix_row(32'hFFFFFFFF));
        directed_plan.push_back(pix_row(32'h00000000));
        directed_plan.push_back(reg_row(iis_pkg::CFG_CHANNELS, 2));
        directed_plan.push_back(reg_row(iis_pkg::CFG_WITH_SQUARES, 0));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_WIDTH, 2));
        directed_plan.push_back(pix_row(32'hFFFFFFFF));
        directed_plan.push_back(pix_row(32'h78563412));
        directed_plan.push_back(pix_row(32'h55AA55AA));
        directed_plan.push_back(pix_row(32'hFFFFFFFF));
        directed_plan.push_back(reg_row(iis_pkg::CFG_CHANNELS, 3));
        directed_plan.push_back(reg_row(iis_pkg::CFG_WITH_SQUARES, 1));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_WIDTH, 1));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_HEIGHT, 4));
        directed_plan.push_back(pix_row(32'hFFFFFFFF));
        directed_plan.push_back(pix_row(32'hFFFFFFFF));
        directed_plan.push_back(reg_row(iis_pkg::CFG_IMAGE_HEIGHT, 2));
        directed_plan.push_back(pix_row(32'hFFFFFFFF));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == STEP_WRITE) begin
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_value);
            end else begin
                push_pixel(directed_plan[i].px, directed_plan[i].known, directed_plan[i].want);
            end
        end

        while (random_pixels < 500 || frames_run <= 12) begin
            calm = (random_pixels >= 420);
            if (frames_run == 6) begin
                run_frame(1'b1, 12'hFFF, 12'd2, random_pixels);
            end else if (frames_run == 12) begin
                run_frame(1'b1, 12'd1, 12'hFFF, random_pixels);
            end else begin
                run_frame(1'b0, '0, '0, random_pixels);
            end
        end
        i_s_tvalid = 1'b0;

        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d pixels in %0d directed rows and %0d random frames, two oversized and cut;",
                 pixels_sent, directed_plan.size(), frames_run);
        $display("%0d results checked in %0d cycles, %0d mismatches",
                 results_seen, cycles, mismatches);
        if (mismatches == 0 && results_seen == pixels_sent) begin
            $display("tb_integral_image_with_squares OK");
        end else begin
            $display("tb_integral_image_with_squares NOT OK");
        end
        $finish;
    end

endmodule
